// ===== rtl/fsls_pkg.sv =====
// ----------------------------------------------------------------------------
// fsls_pkg: shared types and constants of the slot log store
// Slot geometry, operation codes, payload structs and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package fsls_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef logic [IDX_W-1:0] slot_idx_t;

    localparam slot_idx_t FIRST_SLOT = '0;
    localparam slot_idx_t LAST_SLOT  = slot_idx_t'(SLOT_COUNT - 1);

    localparam logic [7:0]  FREE_MARK   = 8'hFF;
    localparam logic [15:0] ERASED_SLOT = 16'hFFFF;

    // Operation codes; the fourth code does nothing.
    localparam logic [1:0] OP_RECOVER   = 2'd0;
    localparam logic [1:0] OP_SET_POWER = 2'd1;
    localparam logic [1:0] OP_SET_MODE  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_POWER_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_MODE_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_DEF_POWER    = 2'd2;
    localparam logic [1:0] CFG_DEF_MODE     = 2'd3;

    localparam logic [7:0] POWER_LIMIT_RST = 8'd1;
    localparam logic [7:0] MODE_LIMIT_RST  = 8'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] new_value;
    } in_item_t;

    typedef struct packed {
        logic [7:0] power_state;
        logic [7:0] restore_mode;
        logic       appended;
        logic       sector_erased;
        logic [3:0] slot_index;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RECOVER,
        ST_APPEND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic      accept;       // item taken, clear result flags
        logic      set_work;     // load new value into the working copy
        logic      rd_en;        // read slot at rd_addr
        slot_idx_t rd_addr;
        logic      wr_en;        // program slot at wr_addr
        slot_idx_t wr_addr;
        logic      erase;        // erase sector before programming
        logic      load_hit;     // load working copy from read slot
        logic      load_default; // load working copy from defaults
    } dp_cmd_t;

    typedef struct packed {
        logic op_recover;  // offered item is a recover
        logic changed;     // offered set item changes its value
        logic rec_ok;      // read slot is used and within limits
        logic slot_free;   // read slot is free
    } dp_status_t;

endpackage

// ===== rtl/fsls_datapath.sv =====
// ----------------------------------------------------------------------------
// fsls_datapath: slot memory, working copy and configuration registers
// Holds the log sector with per-slot valid bits, the registered slot read,
// the compare logic for scanning and the result flags.
// ----------------------------------------------------------------------------
module fsls_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fsls_pkg::in_item_t     in_item,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [7:0]             cfg_data,
    input  fsls_pkg::dp_cmd_t      cmd,
    output fsls_pkg::dp_status_t   status,
    output fsls_pkg::out_item_t    result
);
    import fsls_pkg::*;

    logic [15:0]           slot_mem_reg [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [SLOT_COUNT-1:0] valid_next;
    logic [15:0]           rd_data_reg;
    logic [15:0]           wr_data;
    logic [15:0]           pair;

    logic [7:0] power_limit_reg;
    logic [7:0] mode_limit_reg;
    logic [7:0] def_power_reg;
    logic [7:0] def_mode_reg;
    logic [7:0] work_power_reg;
    logic [7:0] work_mode_reg;
    logic       appended_reg;
    logic       erased_reg;
    logic [3:0] slot_reg;

    assign pair = {work_mode_reg, work_power_reg};

    // A fresh sector reads all ones, so programming right after an erase
    // writes the pair as it is.
    assign wr_data = cmd.erase ? pair : (rd_data_reg & pair);

    always_comb
    begin
        valid_next = cmd.erase ? '0 : valid_reg;
        if (cmd.wr_en)
        begin
            valid_next[cmd.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            slot_mem_reg[cmd.wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= valid_reg[cmd.rd_addr] ? slot_mem_reg[cmd.rd_addr] : ERASED_SLOT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            power_limit_reg <= POWER_LIMIT_RST;
            mode_limit_reg  <= MODE_LIMIT_RST;
            def_power_reg   <= '0;
            def_mode_reg    <= '0;
            work_power_reg  <= '0;
            work_mode_reg   <= '0;
            appended_reg    <= 1'b0;
            erased_reg      <= 1'b0;
            slot_reg        <= '0;
        end
        else
        begin
            valid_reg <= valid_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_POWER_LIMIT: power_limit_reg <= cfg_data;
                    CFG_MODE_LIMIT:  mode_limit_reg  <= cfg_data;
                    CFG_DEF_POWER:   def_power_reg   <= cfg_data;
                    CFG_DEF_MODE:    def_mode_reg    <= cfg_data;
                    default:         ;
                endcase
            end

            if (cmd.accept)
            begin
                appended_reg <= 1'b0;
                erased_reg   <= 1'b0;
                slot_reg     <= '0;
            end

            if (cmd.set_work)
            begin
                if (in_item.operation == OP_SET_POWER)
                begin
                    work_power_reg <= in_item.new_value;
                end
                else
                begin
                    work_mode_reg <= in_item.new_value;
                end
            end

            if (cmd.load_hit)
            begin
                work_power_reg <= rd_data_reg[7:0];
                work_mode_reg  <= rd_data_reg[15:8];
            end
            else if (cmd.load_default)
            begin
                work_power_reg <= def_power_reg;
                work_mode_reg  <= def_mode_reg;
            end

            if (cmd.wr_en)
            begin
                appended_reg <= 1'b1;
                slot_reg     <= 4'(cmd.wr_addr);
            end
            if (cmd.erase)
            begin
                erased_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        status.op_recover = (in_item.operation == OP_RECOVER);
        status.changed    = ((in_item.operation == OP_SET_POWER) &&
                             (in_item.new_value != work_power_reg)) ||
                            ((in_item.operation == OP_SET_MODE) &&
                             (in_item.new_value != work_mode_reg));
        status.slot_free  = (rd_data_reg[7:0] == FREE_MARK);
        status.rec_ok     = (rd_data_reg[7:0] != FREE_MARK) &&
                            (rd_data_reg[7:0] <= power_limit_reg) &&
                            (rd_data_reg[15:8] <= mode_limit_reg);
    end

    always_comb
    begin
        result.power_state   = work_power_reg;
        result.restore_mode  = work_mode_reg;
        result.appended      = appended_reg;
        result.sector_erased = erased_reg;
        result.slot_index    = slot_reg;
    end

endmodule

// ===== rtl/fsls_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsls_ctrl: sequencer of the slot log store
// Takes items, walks the slots with a pipelined read (one slot a cycle)
// and issues the load, program and erase commands.
// ----------------------------------------------------------------------------
module fsls_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  fsls_pkg::dp_status_t  status,
    output fsls_pkg::dp_cmd_t     cmd,
    output logic                  busy,
    output logic                  done
);
    import fsls_pkg::*;

    state_t    state_reg, state_next;
    slot_idx_t idx_reg, idx_next;   // next slot to read
    slot_idx_t chk_reg, chk_next;   // slot whose data sits in the read register
    logic      pend_reg, pend_next; // read register holds data to check

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            chk_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            chk_reg   <= chk_next;
            pend_reg  <= pend_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        chk_next   = chk_reg;
        pend_next  = pend_reg;
        cmd        = '0;
        cmd.rd_addr = idx_reg;
        cmd.wr_addr = chk_reg;
        busy       = 1'b1;
        done       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                busy      = 1'b0;
                pend_next = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (status.op_recover)
                    begin
                        idx_next   = LAST_SLOT;
                        state_next = ST_RECOVER;
                    end
                    else if (status.changed)
                    begin
                        cmd.set_work = 1'b1;
                        idx_next     = FIRST_SLOT;
                        state_next   = ST_APPEND;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_RECOVER:
            begin
                if (pend_reg && status.rec_ok)
                begin
                    cmd.load_hit = 1'b1;
                    state_next   = ST_DONE;
                end
                else if (pend_reg && (chk_reg == FIRST_SLOT))
                begin
                    cmd.load_default = 1'b1;
                    state_next       = ST_DONE;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    chk_next  = idx_reg;
                    pend_next = 1'b1;
                    if (idx_reg != FIRST_SLOT)
                    begin
                        idx_next = idx_reg - slot_idx_t'(1);
                    end
                end
            end

            ST_APPEND:
            begin
                if (pend_reg && status.slot_free)
                begin
                    cmd.wr_en  = 1'b1;
                    state_next = ST_DONE;
                end
                else if (pend_reg && (chk_reg == LAST_SLOT))
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.erase   = 1'b1;
                    cmd.wr_addr = FIRST_SLOT;
                    state_next  = ST_DONE;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    chk_next  = idx_reg;
                    pend_next = 1'b1;
                    if (idx_reg != LAST_SLOT)
                    begin
                        idx_next = idx_reg + slot_idx_t'(1);
                    end
                end
            end

            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/flash_slot_log_store.sv =====
// ----------------------------------------------------------------------------
// flash_slot_log_store: wear-levelled two-byte log with a working copy
// Top level: joins the sequencer and the datapath and checks a few rules.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge where start is high and busy is low, and
// exactly one result item follows, shown for a single cycle with done high;
// the receiver cannot hold it off, so it must capture the result in that
// cycle. The log is read through one registered read port, one slot per
// cycle. A recover item checks the slots from the top down until it finds a
// valid one (or all SLOT_COUNT slots when none is valid) and keeps the block
// busy until its result has been shown, so a new item is taken only after
// that. A set item that changes its value scans upward for the first free
// slot in the same way and programs it in the cycle that finds it; if the
// sector is full it erases every slot and programs slot 0 in that same
// cycle. A set item with an unchanged value, and the unused operation code,
// go straight to the result without reading the log. Configuration writes
// through cfg_we, cfg_index and cfg_data take effect at once and are meant
// for idle time. After reset the sector reads as erased and no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module flash_slot_log_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  fsls_pkg::in_item_t   in_item,
    output logic                 done,
    output fsls_pkg::out_item_t  result,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data
);
    import fsls_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The sequencer decides what happens each cycle from the status of the
    // slot just read; the datapath holds all storage.
    fsls_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    fsls_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

`ifndef SYNTHESIS
    // A result is shown only while an item is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside of a busy period");

    // After a result the block is ready for the next item.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("block not idle after a result");

    // An erase always goes with programming slot 0 in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.sector_erased) |-> (result.appended && (result.slot_index == 4'd0)))
        else $error("sector erased without programming slot 0");

    // A recover never programs a slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (in_item.operation == OP_RECOVER)) |=> !cmd.wr_en)
        else $error("recover started a slot write");
`endif

endmodule

// ===== test/flash_slot_log_store_tb.sv =====
// ----------------------------------------------------------------------------
// flash_slot_log_store_tb: self-checking bench for the slot log store
// Drives recover and set items through the start/busy handshake, mirrors the
// log sector, the working copy and the four registers in a local predictor,
// and compares every result item, field by field, with the predicted one.
// ----------------------------------------------------------------------------
module flash_slot_log_store_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fsls_pkg::*;

    // The package names three operation codes; the fourth does nothing.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_COUNT   = 10;
    localparam int PHASE_ITEMS   = 173;
    // The longest item is a scan over every slot of the sector, and this
    // margin covers the tail of any item.
    localparam int SETTLE_CYCLES = 24;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  in_item;
    logic      done;
    out_item_t result;
    logic      cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    // Local copy of the block's state: the sector image, the working pair
    // and the configuration registers.
    logic [15:0] log_image [SLOT_COUNT];
    logic [7:0]  work_power;
    logic [7:0]  work_mode;
    logic [7:0]  power_limit;
    logic [7:0]  mode_limit;
    logic [7:0]  fallback_power;
    logic [7:0]  fallback_mode;

    // Result items still owed by the block, oldest first.
    out_item_t expected_reports [$];

    int error_count = 0;
    int cycle_count = 0;
    bit gaps_on;

    flash_slot_log_store uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_item   (in_item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Applies one item to the local state and returns the result item that
    // the block must produce for it.
    function automatic out_item_t log_step(input in_item_t item);
        out_item_t rep;
        bit        found;
        bit        changed;
        int        free_at;
        rep = '0;
        case (item.operation)
            OP_RECOVER:
            begin
                // Scan from the top slot down; the first used slot within
                // both limits wins, otherwise the defaults are loaded.
                found = 1'b0;
                for (int s = SLOT_COUNT - 1; s >= 0; s--)
                begin
                    if (!found && log_image[s][7:0] != FREE_MARK &&
                        log_image[s][7:0] <= power_limit &&
                        log_image[s][15:8] <= mode_limit)
                    begin
                        found      = 1'b1;
                        work_power = log_image[s][7:0];
                        work_mode  = log_image[s][15:8];
                    end
                end
                if (!found)
                begin
                    work_power = fallback_power;
                    work_mode  = fallback_mode;
                end
            end
            OP_SET_POWER, OP_SET_MODE:
            begin
                if (item.operation == OP_SET_POWER)
                begin
                    changed    = (item.new_value != work_power);
                    work_power = item.new_value;
                end
                else
                begin
                    changed   = (item.new_value != work_mode);
                    work_mode = item.new_value;
                end
                if (changed)
                begin
                    free_at = -1;
                    for (int s = 0; s < SLOT_COUNT; s++)
                    begin
                        if (free_at < 0 && log_image[s][7:0] == FREE_MARK)
                        begin
                            free_at = s;
                        end
                    end
                    // A full sector is erased and the pair lands in slot 0.
                    if (free_at < 0)
                    begin
                        foreach (log_image[s])
                        begin
                            log_image[s] = ERASED_SLOT;
                        end
                        rep.sector_erased = 1'b1;
                        free_at = 0;
                    end
                    // Programming can only clear bits, so the pair is ANDed
                    // into whatever the slot held; this matters when a power
                    // state of 0xFF left a slot that still reads as free.
                    log_image[free_at] = log_image[free_at] & {work_mode, work_power};
                    rep.appended   = 1'b1;
                    rep.slot_index = 4'(free_at);
                end
            end
            default:
            begin
            end
        endcase
        rep.power_state  = work_power;
        rep.restore_mode = work_mode;
        return rep;
    endfunction

    // Offers one item at a falling edge and holds it until a rising edge
    // finds busy low. The expectation is queued at that accepting edge, and
    // start drops at the following falling edge; the block is busy by then.
    task automatic send_item(input in_item_t item);
        @(negedge clk);
        start   <= 1'b1;
        in_item <= item;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        expected_reports.push_back(log_step(item));
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic send_op(input logic [1:0] operation, input logic [7:0] new_value);
        in_item_t item;
        item.operation = operation;
        item.new_value = new_value;
        send_item(item);
    endtask

    // Waits until every owed result has arrived and the block has settled,
    // so that registers can be written while it is idle.
    task automatic wait_drained();
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            CFG_POWER_LIMIT: power_limit    = data;
            CFG_MODE_LIMIT:  mode_limit     = data;
            CFG_DEF_POWER:   fallback_power = data;
            default:         fallback_mode  = data;
        endcase
    endtask

    task automatic set_registers(input logic [7:0] p_limit, input logic [7:0] m_limit,
                                 input logic [7:0] p_default, input logic [7:0] m_default);
        wait_drained();
        write_reg(CFG_POWER_LIMIT, p_limit);
        write_reg(CFG_MODE_LIMIT, m_limit);
        write_reg(CFG_DEF_POWER, p_default);
        write_reg(CFG_DEF_MODE, m_default);
    endtask

    // Sender idling: when gaps are on, now and then a burst of empty cycles.
    task automatic idle_gap();
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
    endtask

    // A recover on the erased sector must load the defaults, and the unused
    // operation code must leave everything as it is.
    task automatic test_reset_state();
        send_op(OP_RECOVER, 8'h00);
        send_op(OP_UNUSED, 8'hFF);
    endtask

    // Appends with changed values, skips with unchanged ones, and the power
    // state 0xFF that programs a slot which still reads as free.
    task automatic test_set_and_append();
        send_op(OP_SET_POWER, 8'h00);
        send_op(OP_SET_POWER, 8'h01);
        send_op(OP_SET_MODE, 8'h02);
        send_op(OP_SET_MODE, 8'h02);
        send_op(OP_SET_POWER, 8'hFF);
        send_op(OP_SET_POWER, 8'h00);
        send_op(OP_RECOVER, 8'hFF);
        send_op(OP_SET_MODE, 8'hFF);
        send_op(OP_RECOVER, 8'h00);
    endtask

    // With both limits at zero no used slot passes, so the defaults load;
    // with both at their maximum the newest used slot is taken.
    task automatic test_default_fallback();
        set_registers(8'h00, 8'h00, 8'hA5, 8'h5A);
        send_op(OP_RECOVER, 8'h00);
        set_registers(8'hFF, 8'hFF, 8'h00, 8'hFF);
        send_op(OP_RECOVER, 8'h00);
    endtask

    // Enough changing sets to fill the sector, erase it and wrap to slot 0.
    task automatic test_sector_wrap();
        set_registers(POWER_LIMIT_RST, MODE_LIMIT_RST, 8'h00, 8'h00);
        for (int n = 0; n < 14; n++)
        begin
            send_op(OP_SET_POWER, 8'((n + 1) % 2));
        end
        send_op(OP_RECOVER, 8'h00);
    endtask

    function automatic in_item_t random_item();
        in_item_t item;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            item.operation = OP_RECOVER;
        end
        else if (pick < 60)
        begin
            item.operation = OP_SET_POWER;
        end
        else if (pick < 95)
        begin
            item.operation = OP_SET_MODE;
        end
        else
        begin
            item.operation = OP_UNUSED;
        end
        // Small values fall within typical limits and repeat often, which
        // gives both recover hits and unchanged sets; 0xFF makes slots that
        // read as free; full-range values toggle every bit.
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            item.new_value = 8'($urandom_range(0, 3));
        end
        else if (pick < 7)
        begin
            item.new_value = FREE_MARK;
        end
        else
        begin
            item.new_value = 8'($urandom);
        end
        return item;
    endfunction

    // Phases of random traffic, each under its own register setting. The
    // first two use the extremes, the last the reset values and no idling.
    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase == 0)
            begin
                set_registers(8'h00, 8'h00, 8'hFF, 8'hFF);
            end
            else if (phase == 1)
            begin
                set_registers(8'hFF, 8'hFF, 8'h00, 8'h00);
            end
            else if (phase == PHASE_COUNT - 1)
            begin
                set_registers(POWER_LIMIT_RST, MODE_LIMIT_RST, 8'h00, 8'h00);
            end
            else
            begin
                set_registers(($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3))
                                                          : 8'($urandom),
                              ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3))
                                                          : 8'($urandom),
                              8'($urandom), 8'($urandom));
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Idling switches on and off in stretches of 40 items.
                if (n % 40 == 0)
                begin
                    gaps_on = (phase < PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
                end
                // Now and then the sender holds off until the block is empty.
                if ($urandom_range(0, 99) == 0)
                begin
                    wait_drained();
                end
                send_item(random_item());
                idle_gap();
            end
        end
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // Result checker: a result item is valid for exactly one cycle and is
    // taken at the rising edge that ends it.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && done)
        begin
            if (expected_reports.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("power_state", want.power_state, result.power_state);
                check_field("restore_mode", want.restore_mode, result.restore_mode);
                check_field("appended", 8'(want.appended), 8'(result.appended));
                check_field("sector_erased", 8'(want.sector_erased), 8'(result.sector_erased));
                check_field("slot_index", 8'(want.slot_index), 8'(result.slot_index));
            end
        end
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        start     = 1'b0;
        in_item   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_POWER_LIMIT;
        cfg_data  = 8'h00;
        rst_n     = 1'b0;
        gaps_on   = 1'b0;

        // The predictor starts from the reset state: erased sector, zero
        // working pair and the register reset values.
        foreach (log_image[s])
        begin
            log_image[s] = ERASED_SLOT;
        end
        work_power     = 8'h00;
        work_mode      = 8'h00;
        power_limit    = POWER_LIMIT_RST;
        mode_limit     = MODE_LIMIT_RST;
        fallback_power = 8'h00;
        fallback_mode  = 8'h00;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_set_and_append();
        test_default_fallback();
        test_sector_wrap();
        test_random_traffic();

        // Let the last results arrive, then watch a while for strays.
        wait_drained();
        if (error_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
